/* rtl/core/vrbm_pkg.sv */
// Shared types and constants of the voxel run box merger.
// Depends on nothing; every file of the block imports it.
package vrbm_pkg;

   localparam int GRID     = 8;
   localparam int MAX_LIST = 32;
   localparam int COORD_W  = 3;
   localparam int EXT_W    = 4;
   localparam int CNT_W    = 6;
   localparam int CELLS    = 1 << COORD_W;
   localparam int KEY_W    = 2 * COORD_W;
   localparam int KEYS     = 1 << KEY_W;

   localparam logic REQ_PUSH   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [COORD_W-1:0] run_x;
      logic [COORD_W-1:0] run_y;
      logic [COORD_W-1:0] run_z;
      logic [EXT_W-1:0]   run_length;
   } vrbm_req_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] box_x0;
      logic [COORD_W-1:0] box_y0;
      logic [COORD_W-1:0] box_z0;
      logic [EXT_W-1:0]   box_x1;
      logic [EXT_W-1:0]   box_y1;
      logic [EXT_W-1:0]   box_z1;
      logic               order_error;
      logic               is_last;
   } vrbm_rsp_item_type;

   // occupancy of one layer: [y][x]
   typedef logic [CELLS-1:0][CELLS-1:0] vrbm_layer_type;

   // box of the current layer that starts at the probed cell
   typedef struct packed {
      logic             start;
      logic [EXT_W-1:0] x1;
      logic [EXT_W-1:0] y1;
   } vrbm_span_type;

endpackage

/* rtl/core/vrbm_span_unit.sv */
// Span probe: finds the y-merged box that starts at one cell of the layer map.
// Depends on vrbm_pkg.
module vrbm_span_unit (
   input  vrbm_pkg::vrbm_layer_type   layer,
   input  logic [vrbm_pkg::COORD_W-1:0] key_x,
   input  logic [vrbm_pkg::COORD_W-1:0] key_y,
   output vrbm_pkg::vrbm_span_type    span
);
   import vrbm_pkg::*;

   localparam int WIDE_W = CELLS + 1;

   logic [CELLS-1:0]  row;
   logic [EXT_W-1:0]  x1;
   logic [EXT_W-1:0]  y1;
   logic [WIDE_W-1:0] seg_mask;
   logic [WIDE_W-1:0] ext_mask;
   logic [CELLS-1:0]  match;
   logic              left_clear;
   logic              above;

   always_comb begin
      row = layer[key_y];
      // first empty cell at or right of key_x closes the span
      x1 = EXT_W'(CELLS);
      for (int i = CELLS - 1; i >= 0; i--) begin
         if (i >= int'(key_x) && !row[i]) begin
            x1 = EXT_W'(i);
         end
      end
      seg_mask = ((WIDE_W'(1) << x1) - WIDE_W'(1)) & ~((WIDE_W'(1) << key_x) - WIDE_W'(1));
      // a row holds the same span only if both neighbors are empty
      ext_mask = seg_mask | (WIDE_W'(1) << x1);
      if (key_x != '0) begin
         ext_mask = ext_mask | (WIDE_W'(1) << COORD_W'(key_x - 1'b1));
      end
      for (int r = 0; r < CELLS; r++) begin
         match[r] = (({1'b0, layer[r]} & ext_mask) == seg_mask);
      end
      left_clear = (key_x == '0) || !row[COORD_W'(key_x - 1'b1)];
      above      = (key_y != '0) && match[COORD_W'(key_y - 1'b1)];
      y1 = EXT_W'(CELLS);
      for (int r = CELLS - 1; r >= 0; r--) begin
         if (r > int'(key_y) && !match[r]) begin
            y1 = EXT_W'(r);
         end
      end
      span.start = row[key_x] && left_clear && !above;
      span.x1    = x1;
      span.y1    = y1;
   end

endmodule

/* rtl/core/voxel_run_box_merger_top.sv */
// Top level of the voxel run box merger: run intake, layer map, open box table.
// Depends on vrbm_pkg and vrbm_span_unit.
//
// channel | ports                          | direction | moves
// --------+--------------------------------+-----------+--------------------------
// request | req_valid req_stall req_item   | in        | one run or finish item
// result  | rsp_valid rsp_stall rsp_item   | out       | one box or error item
//
// A push inside the current layer passes through accept and drain. A push that
// opens a new layer walks all 64 cells of the grid through the span probe and
// the open box table, with a read and an evaluate step per cell; output stalls
// can hold the walk. A finish takes up to two such walks (close, dump).
// Reset is synchronous and needs no clearing pass. A stalled result port halts
// the walk only when a second box is waiting behind the one already held.
module voxel_run_box_merger_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  vrbm_pkg::vrbm_req_item_type   req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vrbm_pkg::vrbm_rsp_item_type   rsp_item
);
   import vrbm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   // open box of the previous layer, keyed by its low (y,x) corner
   typedef struct packed {
      logic [EXT_W-1:0]   x1;
      logic [EXT_W-1:0]   y1;
      logic [COORD_W-1:0] z0;
   } entry_type;

   function automatic logic [CELLS-1:0] run_mask(input logic [COORD_W-1:0] x,
                                                 input logic [EXT_W-1:0] len);
      logic [2*CELLS-1:0] wide;
      wide = ((2*CELLS)'(1) << len) - (2*CELLS)'(1);
      wide = wide << x;
      return wide[CELLS-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic               dump_ff, dump_in;      // walk emits every open box
   logic               finish_ff, finish_in;  // close walk is followed by a dump
   logic [COORD_W-1:0] key_x_ff, key_x_in;
   logic [COORD_W-1:0] key_y_ff, key_y_in;
   vrbm_layer_type     layer_ff, layer_in;
   logic [KEYS-1:0]    valid_ff;
   entry_type          table_mem [KEYS];
   entry_type          rd_ff;
   vrbm_span_type      span_ff;
   vrbm_span_type      span_now;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COORD_W-1:0] curz_ff, curz_in;
   logic [COORD_W-1:0] last_x_ff, last_x_in;
   logic [COORD_W-1:0] last_y_ff, last_y_in;
   logic [EXT_W-1:0]   last_len_ff, last_len_in;
   logic [EXT_W-1:0]   tab_z1_ff, tab_z1_in;
   vrbm_req_item_type  run_ff, run_in;
   vrbm_rsp_item_type  hold_ff, hold_in;
   logic               hold_valid_ff, hold_valid_in;
   vrbm_rsp_item_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [KEY_W-1:0]   key;
   logic               key_last;
   logic               out_free;
   logic               cont;
   logic               emit_need;
   logic               mem_we;
   entry_type          mem_wd;
   logic               valid_we;
   logic               valid_wd;
   logic               valid_clear;
   logic [4:0]         last_end;
   logic [4:0]         req_end;
   logic               bad_run;
   vrbm_rsp_item_type  err_item;
   vrbm_rsp_item_type  box_item;

   vrbm_span_unit u_span (
      .layer (layer_ff),
      .key_x (key_x_ff),
      .key_y (key_y_ff),
      .span  (span_now)
   );

   assign key      = {key_y_ff, key_x_ff};
   assign key_last = (key_x_ff == COORD_W'(GRID - 1)) && (key_y_ff == COORD_W'(GRID - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_end = 5'(last_x_ff) + 5'(last_len_ff);
   assign req_end  = 5'(req_item.run_x) + 5'(req_item.run_length);
   assign bad_run  = (req_item.run_length == '0) || (5'(req_item.run_x) >= 5'(GRID)) ||
                     (5'(req_item.run_y) >= 5'(GRID)) || (5'(req_item.run_z) >= 5'(GRID)) ||
                     (req_end > 5'(GRID));

   // previous-layer box continues straight up into the new layer's box
   assign cont = valid_ff[key] && span_ff.start && (rd_ff.x1 == span_ff.x1) &&
                 (rd_ff.y1 == span_ff.y1) && (tab_z1_ff == EXT_W'(curz_ff));
   assign emit_need = valid_ff[key] && (dump_ff || !cont);

   always_comb begin
      err_item             = '0;
      err_item.order_error = 1'b1;
      box_item             = '0;
      box_item.box_x0      = key_x_ff;
      box_item.box_y0      = key_y_ff;
      box_item.box_z0      = rd_ff.z0;
      box_item.box_x1      = rd_ff.x1;
      box_item.box_y1      = rd_ff.y1;
      box_item.box_z1      = tab_z1_ff;
   end

   always_comb begin
      state_in      = state_ff;
      dump_in       = dump_ff;
      finish_in     = finish_ff;
      key_x_in      = key_x_ff;
      key_y_in      = key_y_ff;
      layer_in      = layer_ff;
      count_in      = count_ff;
      curz_in       = curz_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      last_len_in   = last_len_ff;
      tab_z1_in     = tab_z1_ff;
      run_in        = run_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;
      mem_wd        = '0;
      valid_we      = 1'b0;
      valid_wd      = 1'b0;
      valid_clear   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               run_in   = req_item;
               key_x_in = '0;
               key_y_in = '0;
               if (req_item.req_type == REQ_FINISH) begin
                  finish_in = 1'b1;
                  dump_in   = (count_ff == '0);
                  state_in  = ST_READ;
               end else if (bad_run) begin
                  hold_in       = err_item;
                  hold_valid_in = 1'b1;
                  state_in      = ST_FLUSH;
               end else if (count_ff != '0 && curz_ff != req_item.run_z) begin
                  if (curz_ff > req_item.run_z) begin
                     hold_in       = err_item;
                     hold_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end else begin
                     // new layer: close the pending one first
                     finish_in = 1'b0;
                     dump_in   = 1'b0;
                     state_in  = ST_READ;
                  end
               end else begin
                  state_in = ST_FLUSH;
                  if (count_ff != '0 && ((last_y_ff > req_item.run_y) ||
                      (last_y_ff == req_item.run_y && last_end > 5'(req_item.run_x)))) begin
                     hold_in       = err_item;
                     hold_valid_in = 1'b1;
                  end else if (count_ff != '0 && last_y_ff == req_item.run_y &&
                               last_end == 5'(req_item.run_x)) begin
                     last_len_in = last_len_ff + req_item.run_length;
                     layer_in[req_item.run_y] = layer_ff[req_item.run_y] |
                        run_mask(req_item.run_x, req_item.run_length);
                  end else if (count_ff >= CNT_W'(MAX_LIST)) begin
                     hold_in       = err_item;
                     hold_valid_in = 1'b1;
                  end else begin
                     layer_in[req_item.run_y] = layer_ff[req_item.run_y] |
                        run_mask(req_item.run_x, req_item.run_length);
                     last_x_in   = req_item.run_x;
                     last_y_in   = req_item.run_y;
                     last_len_in = req_item.run_length;
                     count_in    = count_ff + CNT_W'(1);
                     curz_in     = req_item.run_z;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!emit_need || !hold_valid_ff || out_free) begin
               if (emit_need) begin
                  if (hold_valid_ff) begin
                     rsp_in       = hold_ff;
                     rsp_valid_in = 1'b1;
                  end
                  hold_in       = box_item;
                  hold_valid_in = 1'b1;
               end
               valid_we = 1'b1;
               if (!dump_ff) begin
                  valid_wd  = span_ff.start;
                  mem_we    = span_ff.start;
                  mem_wd.x1 = span_ff.x1;
                  mem_wd.y1 = span_ff.y1;
                  mem_wd.z0 = cont ? rd_ff.z0 : curz_ff;
               end
               if (key_last) begin
                  key_x_in = '0;
                  key_y_in = '0;
                  if (!dump_ff) begin
                     tab_z1_in = EXT_W'(curz_ff) + EXT_W'(1);
                     layer_in  = '0;
                     if (finish_ff) begin
                        dump_in  = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        // the run that opened this layer becomes its first entry
                        layer_in[run_ff.run_y] = run_mask(run_ff.run_x, run_ff.run_length);
                        last_x_in   = run_ff.run_x;
                        last_y_in   = run_ff.run_y;
                        last_len_in = run_ff.run_length;
                        count_in    = CNT_W'(1);
                        curz_in     = run_ff.run_z;
                        state_in    = ST_FLUSH;
                     end
                  end else begin
                     valid_clear = 1'b1;
                     layer_in    = '0;
                     count_in    = '0;
                     curz_in     = '0;
                     state_in    = ST_FLUSH;
                  end
               end else begin
                  if (key_x_ff == COORD_W'(GRID - 1)) begin
                     key_x_in = '0;
                     key_y_in = key_y_ff + COORD_W'(1);
                  end else begin
                     key_x_in = key_x_ff + COORD_W'(1);
                  end
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            // the held item is the last one this request causes
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_in         = hold_ff;
               rsp_in.is_last = 1'b1;
               rsp_valid_in   = 1'b1;
               hold_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         layer_ff      <= '0;
         valid_ff      <= '0;
         count_ff      <= '0;
         curz_ff       <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         layer_ff      <= layer_in;
         count_ff      <= count_in;
         curz_ff       <= curz_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (valid_clear) begin
            valid_ff <= '0;
         end else if (valid_we) begin
            valid_ff[key] <= valid_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      dump_ff     <= dump_in;
      finish_ff   <= finish_in;
      key_x_ff    <= key_x_in;
      key_y_ff    <= key_y_in;
      last_x_ff   <= last_x_in;
      last_y_ff   <= last_y_in;
      last_len_ff <= last_len_in;
      tab_z1_ff   <= tab_z1_in;
      run_ff      <= run_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      if (state_ff == ST_READ) begin
         span_ff <= span_now;
      end
   end

   // open box table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[key] <= mem_wd;
      end
      if (state_ff == ST_READ) begin
         rd_ff <= table_mem[key];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("held item left over at idle");
   a_count_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((count_ff == '0) == (layer_ff == '0)))
      else $error("pending count and layer map disagree");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LIST))
      else $error("pending count beyond list size");
`endif

endmodule
